// File: rtl/base64_stream_codec_assert.svh
// assertion macros for the base64 stream codec checker
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

// same-cycle implication, checked on clk, off while in reset
`define B64_ASSERT_IMPLY(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("b64 checker: implication violated");

// next-cycle implication, checked on clk, off while in reset
`define B64_ASSERT_NEXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("b64 checker: next-cycle implication violated");

`endif

// File: rtl/b64_pkg.sv
// shared types, constants and character mapping functions for the base64 stream codec
package b64_pkg;

	// results one input beat can cause, and the width of a count of them
	localparam int unsigned NUM_SLOTS = 6;
	localparam int unsigned SLOT_W    = 3;

	// line length of the encoded text and the saturation point of the counter
	localparam logic [6:0] LINE_LIMIT = 7'd76;
	localparam logic [6:0] LINE_MAX   = 7'd127;

	// special characters
	localparam logic [7:0] CHAR_CR  = 8'h0d;
	localparam logic [7:0] CHAR_LF  = 8'h0a;
	localparam logic [7:0] CHAR_PAD = 8'h3d;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_BREAKS = 2'd1;

	// work record handed from the front end to the back end
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] chars;
		logic [SLOT_W-1:0]         cnt;
		logic                      data_valid;
		logic                      last;
		logic                      stopped;
	} b64_rec_t;

	// sextet to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		if (v < 6'd26) begin
			return 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			return 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			return 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			return 8'h2b;
		end else begin
			return 8'h2f;
		end
	endfunction

	// alphabet character to sextet, bit 6 set for anything outside the alphabet
	function automatic logic [6:0] dec_sextet(input logic [7:0] c);
		if (c inside {[8'h41:8'h5a]}) begin
			return {1'b0, 6'(c - 8'h41)};
		end else if (c inside {[8'h61:8'h7a]}) begin
			return {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c inside {[8'h30:8'h39]}) begin
			return {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2b) begin
			return 7'd62;
		end else if (c == 8'h2f) begin
			return 7'd63;
		end else begin
			return 7'd64;
		end
	endfunction

endpackage

// File: rtl/base64_stream_codec.sv
// Base64 stream codec top level. Input beats enter a front end that runs the encoder or decoder
// and packs every result one beat causes (up to six) into a work record; a two-record queue
// sits between it and a back end that hands out one result per cycle, while the output register
// is free or popped, through that register. An input beat is taken in the cycle it arrives while
// the queue has room, so the input never waits on its own work and new beats can be taken while
// earlier results are still handed out. A result passes through the queue's head register and
// then the output register before it shows on the output ports. No clearing is needed after
// reset.
module base64_stream_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic                          out_last,
	output logic                          decode_stopped,
	input  logic                          cfg_we,
	input  logic [b64_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_wdata
);

	logic                accept;
	logic                rec_push;
	b64_pkg::b64_rec_t   rec;
	b64_pkg::b64_rec_t   head_rec;
	logic                q_head_vld;
	logic                q_take;

	// input beat handshake
	assign accept = push && !full;

	// front end
	b64_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rec_push  (rec_push),
		.rec       (rec)
	);

	// record queue
	b64_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_push),
		.push_rec (rec),
		.full     (full),
		.head_rec (head_rec),
		.head_vld (q_head_vld),
		.take     (q_take)
	);

	// back end
	b64_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_rec       (head_rec),
		.head_vld       (q_head_vld),
		.take           (q_take),
		.pop            (pop),
		.empty          (empty),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.out_last       (out_last),
		.decode_stopped (decode_stopped)
	);

endmodule

// File: rtl/b64_front.sv
// front end: accepts input beats, keeps the codec state, builds a work record for each beat that gives a result
module b64_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [7:0]                       in_byte,
	input  logic                             in_last,
	input  logic                             cfg_we,
	input  logic [b64_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                             cfg_wdata,
	output logic                             rec_push,
	output b64_pkg::b64_rec_t                rec
);

	logic                  encode_q;
	logic                  breaks_q;
	logic [1:0]            phase_q;
	logic [7:0]            carry_q;
	logic [6:0]            line_q;
	logic                  stopped_q;

	logic [1:0]            ph;
	logic [1:0]            phase_nxt;
	logic [7:0]            carry_nxt;
	logic [6:0]            line_nxt;
	logic [8:0]            line_sum;
	logic [1:0]            add_cnt;
	logic                  stop_nxt;
	logic [6:0]            sx;
	logic [b64_pkg::SLOT_W-1:0] n;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_q <= 1'b1;
			breaks_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				b64_pkg::CFG_ENCODE_MODE: encode_q <= cfg_wdata;
				b64_pkg::CFG_LINE_BREAKS: breaks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// per-beat encode / decode and record assembly
	always_comb begin
		n         = '0;
		rec.chars = '0;
		ph        = (phase_q == 2'd3) ? 2'd0 : phase_q;
		phase_nxt = phase_q;
		carry_nxt = carry_q;
		line_nxt  = line_q;
		line_sum  = '0;
		add_cnt   = 2'd1;
		stop_nxt  = stopped_q;
		sx        = b64_pkg::dec_sextet(in_byte);

		if (encode_q) begin
			// split the byte over the current group
			case (ph)
				2'd0: begin
					rec.chars[n] = b64_pkg::enc_char(in_byte[7:2]);
					n = n + 3'd1;
					carry_nxt = {2'b00, in_byte[1:0], 4'b0000};
				end
				2'd1: begin
					rec.chars[n] = b64_pkg::enc_char(carry_q[5:0] | {2'b00, in_byte[7:4]});
					n = n + 3'd1;
					carry_nxt = {2'b00, in_byte[3:0], 2'b00};
				end
				default: begin
					rec.chars[n] = b64_pkg::enc_char(carry_q[5:0] | {4'b0000, in_byte[7:6]});
					n = n + 3'd1;
					rec.chars[n] = b64_pkg::enc_char(in_byte[5:0]);
					n = n + 3'd1;
					add_cnt = 2'd2;
				end
			endcase
			phase_nxt = (ph == 2'd2) ? 2'd0 : ph + 2'd1;

			// saturating character count on the line
			line_sum = {2'b00, line_q} + {7'b0, add_cnt};
			line_nxt = (line_sum > {2'b00, b64_pkg::LINE_MAX}) ? b64_pkg::LINE_MAX : line_sum[6:0];

			// line break once the line is full
			if (breaks_q && line_nxt >= b64_pkg::LINE_LIMIT) begin
				rec.chars[n] = b64_pkg::CHAR_CR;
				n = n + 3'd1;
				rec.chars[n] = b64_pkg::CHAR_LF;
				n = n + 3'd1;
				line_nxt = '0;
			end

			// close the message: partial group with padding, then a final break
			if (in_last) begin
				if (phase_nxt != 2'd0) begin
					rec.chars[n] = b64_pkg::enc_char(carry_nxt[5:0]);
					n = n + 3'd1;
					rec.chars[n] = b64_pkg::CHAR_PAD;
					n = n + 3'd1;
					if (phase_nxt == 2'd1) begin
						rec.chars[n] = b64_pkg::CHAR_PAD;
						n = n + 3'd1;
					end
				end
				if (breaks_q && line_nxt != 7'd0) begin
					rec.chars[n] = b64_pkg::CHAR_CR;
					n = n + 3'd1;
					rec.chars[n] = b64_pkg::CHAR_LF;
					n = n + 3'd1;
				end
			end
		end else begin
			// decode: skip line breaks, stop on padding or a foreign character
			if (!stopped_q && in_byte != b64_pkg::CHAR_CR && in_byte != b64_pkg::CHAR_LF) begin
				if (sx[6]) begin
					stop_nxt = 1'b1;
				end else begin
					case (phase_q)
						2'd0: begin
							carry_nxt = {sx[5:0], 2'b00};
						end
						2'd1: begin
							rec.chars[n] = carry_q | {6'b0, sx[5:4]};
							n = n + 3'd1;
							carry_nxt = {sx[3:0], 4'b0000};
						end
						2'd2: begin
							rec.chars[n] = carry_q | {4'b0, sx[5:2]};
							n = n + 3'd1;
							carry_nxt = {sx[1:0], 6'b0};
						end
						default: begin
							rec.chars[n] = carry_q | {2'b0, sx[5:0]};
							n = n + 3'd1;
						end
					endcase
					phase_nxt = phase_q + 2'd1;
				end
			end
		end

		// bare end marker when the last beat gave nothing
		rec.data_valid = 1'b1;
		if (in_last && n == 3'd0) begin
			rec.chars[0]   = 8'h00;
			rec.data_valid = 1'b0;
			n = 3'd1;
		end

		rec.cnt     = n;
		rec.last    = in_last;
		rec.stopped = !encode_q && stop_nxt;
		rec_push    = accept && (n != 3'd0);
	end

	// codec state, cleared at the end of every message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			carry_q   <= '0;
			line_q    <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				phase_q   <= '0;
				carry_q   <= '0;
				line_q    <= '0;
				stopped_q <= 1'b0;
			end else begin
				phase_q   <= phase_nxt;
				carry_q   <= carry_nxt;
				line_q    <= line_nxt;
				stopped_q <= stop_nxt;
			end
		end
	end

endmodule

// File: rtl/b64_queue.sv
// two-entry shift queue of work records between front and back end
module b64_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64_pkg::b64_rec_t    push_rec,
	output logic                 full,
	output b64_pkg::b64_rec_t    head_rec,
	output logic                 head_vld,
	input  logic                 take
);

	b64_pkg::b64_rec_t head_q;
	b64_pkg::b64_rec_t tail_q;
	logic              head_vld_q;
	logic              tail_vld_q;

	assign full     = tail_vld_q;
	assign head_rec = head_q;
	assign head_vld = head_vld_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else begin
			case ({push, take})
				2'b10: begin
					if (head_vld_q) begin
						tail_vld_q <= 1'b1;
					end else begin
						head_vld_q <= 1'b1;
					end
				end
				2'b01: begin
					head_vld_q <= tail_vld_q;
					tail_vld_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// record storage, head always in the first slot
	always_ff @(posedge clk) begin
		case ({push, take})
			2'b10: begin
				if (head_vld_q) begin
					tail_q <= push_rec;
				end else begin
					head_q <= push_rec;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (tail_vld_q) begin
					head_q <= tail_q;
					tail_q <= push_rec;
				end else begin
					head_q <= push_rec;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/b64_back.sv
// back end: walks the head record one result per cycle into the output register while it is free or popped
module b64_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64_pkg::b64_rec_t    head_rec,
	input  logic                 head_vld,
	output logic                 take,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 byte_valid,
	output logic                 out_last,
	output logic                 decode_stopped
);

	logic [b64_pkg::SLOT_W-1:0] idx_q;
	logic                       out_vld_q;
	logic [7:0]                 byte_q;
	logic                       bvalid_q;
	logic                       last_q;
	logic                       stop_q;
	logic                       emit;
	logic                       at_end;

	// move a result when the output register is free or being drained
	assign emit   = head_vld && (!out_vld_q || pop);
	assign at_end = (idx_q == head_rec.cnt - 3'd1);
	assign take   = emit && at_end;

	assign empty          = !out_vld_q;
	assign out_byte       = byte_q;
	assign byte_valid     = bvalid_q;
	assign out_last       = last_q;
	assign decode_stopped = stop_q;

	// slot index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q     <= at_end ? '0 : idx_q + 3'd1;
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q   <= head_rec.chars[idx_q];
			bvalid_q <= head_rec.data_valid;
			last_q   <= head_rec.last && at_end;
			stop_q   <= head_rec.stopped;
		end
	end

endmodule

// File: rtl/b64_checker.sv
// port-level checker for the base64 stream codec, bound to the top level
`include "base64_stream_codec_assert.svh"

module b64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       out_last,
	input logic       decode_stopped
);

	// a result without data only closes a message, with a zero byte
	`B64_ASSERT_IMPLY(a_marker_is_last, !empty && !byte_valid, out_last && out_byte == 8'h00)

	// the stop flag only shows on the closing marker
	`B64_ASSERT_IMPLY(a_stop_on_marker, !empty && decode_stopped, !byte_valid && out_last)

	// a waiting result holds until taken
	`B64_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last))

endmodule

bind base64_stream_codec b64_checker u_b64_checker (.*);
